/* sv/cacarb_pkg.sv */
// ----------------------------------------------------------------------------
// cacarb_pkg
// Shared types, codes and helpers for the CAN address-claim arbiter.
// ----------------------------------------------------------------------------
package cacarb_pkg;

  localparam int PORTS_DEFAULT = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] ADDR_NULL       = 8'd254;
  localparam logic [7:0] ADDR_GLOBAL     = 8'd255;
  localparam logic [7:0] RANGE_START_RST = 8'd128;
  localparam logic [7:0] RANGE_END_RST   = 8'd247;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_CLAIM   = 2'd1,
    MODE_REQUEST = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC   = 3'd0,
    CFG_NAME0  = 3'd1,
    CFG_NAME1  = 3'd2,
    CFG_START0 = 3'd3,
    CFG_END0   = 3'd4,
    CFG_START1 = 3'd5,
    CFG_END1   = 3'd6
  } cfg_idx_t;

  // One decoded item waiting for the output side.
  typedef struct packed {
    logic       multi;   // sync mode: one beat per port, port 0 first
    logic       name0;   // sync mode: every beat carries the port 0 NAME
    logic       port;    // port of the single beat
    logic [7:0] addr_a;  // held address of the single beat, or of port 0
    logic [7:0] addr_b;  // held address of port 1 (sync only)
    logic       filt;
    logic [7:0] faddr;
    logic       store;
  } job_t;

  // Number of addresses in a range; empty when the end is below the start.
  function automatic logic [8:0] span(input logic [7:0] first, input logic [7:0] final_a);
    logic [8:0] s;
    if (final_a < first) begin
      s = 9'd0;
    end else begin
      s = {1'b0, final_a} - {1'b0, first} + 9'd1;
    end
    return s;
  endfunction

endpackage

/* sv/cacarb_in_if.sv */
// ----------------------------------------------------------------------------
// cacarb_in_if
// Event channel: start claim, received claim or request for claims.
// ----------------------------------------------------------------------------
interface cacarb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        port;
  logic [7:0]  address;
  logic [63:0] their_name;

  modport source (output valid, mode, port, address, their_name, input ready);
  modport sink   (input valid, mode, port, address, their_name, output ready);
endinterface

/* sv/cacarb_out_if.sv */
// ----------------------------------------------------------------------------
// cacarb_out_if
// Result channel: address claim messages and filter updates.
// ----------------------------------------------------------------------------
interface cacarb_out_if;
  logic        valid;
  logic        ready;
  logic        claim_port;
  logic [7:0]  claim_source;
  logic [63:0] claim_name;
  logic        cannot_claim;
  logic        filter_update;
  logic [7:0]  filter_address;
  logic        store_address;
  logic        last;

  modport source (output valid, claim_port, claim_source, claim_name, cannot_claim,
                  filter_update, filter_address, store_address, last, input ready);
  modport sink   (input valid, claim_port, claim_source, claim_name, cannot_claim,
                  filter_update, filter_address, store_address, last, output ready);
endinterface

/* sv/cacarb_front.sv */
// ----------------------------------------------------------------------------
// cacarb_front
// Config registers, per-port address state and claim arbitration.
// ----------------------------------------------------------------------------
module cacarb_front #(
  parameter int PORTS = cacarb_pkg::PORTS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cacarb_in_if.sink                       in_bus,
  input  logic                            cfg_we,
  input  logic [cacarb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                     cfg_data,
  output cacarb_pkg::job_t                job,
  output logic                            push,
  input  logic                            full,
  output logic [PORTS-1:0][63:0]          names
);

  logic                  sync_r,  sync_nxt;
  logic [PORTS-1:0][63:0] name_r,  name_nxt;
  logic [PORTS-1:0][7:0]  start_r, start_nxt;
  logic [PORTS-1:0][7:0]  end_r,   end_nxt;
  logic [PORTS-1:0][7:0]  addr_r,  addr_nxt;
  logic [PORTS-1:0][8:0]  rem_r,   rem_nxt;

  logic        fire, port_ok, c, lose, selfcfg, match, wrap;
  logic [7:0]  cur, cstart, cend, step, stepped, na;
  logic [63:0] cname;
  logic [8:0]  crem;
  cacarb_pkg::mode_t mode;

  assign mode         = cacarb_pkg::mode_t'(in_bus.mode);
  assign in_bus.ready = !full;
  assign fire         = in_bus.valid && !full;
  assign port_ok      = (PORTS > 1) || !in_bus.port;
  assign c            = sync_r ? 1'b0 : in_bus.port;
  assign names        = name_r;

  // arbitration view of port c
  always_comb begin
    cur    = addr_r[0];
    cname  = name_r[0];
    cstart = start_r[0];
    cend   = end_r[0];
    crem   = rem_r[0];
    for (int i = 0; i < PORTS; i++) begin
      if (i == int'(c)) begin
        cur    = addr_r[i];
        cname  = name_r[i];
        cstart = start_r[i];
        cend   = end_r[i];
        crem   = rem_r[i];
      end
    end
  end

  assign step    = cur + 8'd1;
  assign wrap    = (step > cend) || (step < cstart);
  assign stepped = wrap ? cstart : step;
  assign lose    = cname >= in_bus.their_name;
  assign selfcfg = cname[63] && (crem != 9'd0);
  assign na      = selfcfg ? stepped : cacarb_pkg::ADDR_NULL;
  assign match   = (in_bus.address != cacarb_pkg::ADDR_NULL) && (in_bus.address == cur);

  always_comb begin
    sync_nxt  = sync_r;
    name_nxt  = name_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    push      = 1'b0;
    job       = '0;

    // config writes; a range write reloads the count
    if (cfg_we) begin
      if (cfg_index == cacarb_pkg::CFG_SYNC) begin
        sync_nxt = cfg_data[0];
      end
      for (int i = 0; i < PORTS; i++) begin
        if (cfg_index == ((i == 0) ? cacarb_pkg::CFG_NAME0 : cacarb_pkg::CFG_NAME1)) begin
          name_nxt[i] = cfg_data;
        end
        if (cfg_index == ((i == 0) ? cacarb_pkg::CFG_START0 : cacarb_pkg::CFG_START1)) begin
          start_nxt[i] = cfg_data[7:0];
          rem_nxt[i]   = cacarb_pkg::span(cfg_data[7:0], end_r[i]);
        end
        if (cfg_index == ((i == 0) ? cacarb_pkg::CFG_END0 : cacarb_pkg::CFG_END1)) begin
          end_nxt[i] = cfg_data[7:0];
          rem_nxt[i] = cacarb_pkg::span(start_r[i], cfg_data[7:0]);
        end
      end
    end

    job.multi = sync_r;
    job.name0 = sync_r;
    job.port  = c;
    if (fire && port_ok) begin
      unique case (mode)
        cacarb_pkg::MODE_START: begin
          push      = 1'b1;
          job.multi = 1'b0;
          job.port  = in_bus.port;
          for (int i = 0; i < PORTS; i++) begin
            if (i == int'(in_bus.port)) begin
              addr_nxt[i] = (in_bus.address == cacarb_pkg::ADDR_GLOBAL) ?
                            cacarb_pkg::ADDR_NULL : in_bus.address;
            end
          end
        end
        cacarb_pkg::MODE_CLAIM: begin
          if (match) begin
            push = 1'b1;
            if (lose) begin
              job.filt  = 1'b1;
              job.faddr = selfcfg ? stepped : cacarb_pkg::ADDR_GLOBAL;
              job.store = selfcfg && !c;
              for (int i = 0; i < PORTS; i++) begin
                if (sync_r || (i == int'(c))) begin
                  addr_nxt[i] = na;
                end
                if (selfcfg && (i == int'(c))) begin
                  rem_nxt[i] = crem - 9'd1;
                end
              end
            end
          end
        end
        cacarb_pkg::MODE_REQUEST: begin
          push = 1'b1;
        end
        cacarb_pkg::MODE_UNUSED: begin
          push = 1'b0;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end

    // beats carry the addresses as they stand after this item
    job.addr_a = addr_nxt[0];
    job.addr_b = addr_nxt[0];
    for (int i = 0; i < PORTS; i++) begin
      if (!job.multi && (i == int'(job.port))) begin
        job.addr_a = addr_nxt[i];
      end
      if (i == 1) begin
        job.addr_b = addr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= 1'b0;
      for (int i = 0; i < PORTS; i++) begin
        name_r[i]  <= '0;
        start_r[i] <= cacarb_pkg::RANGE_START_RST;
        end_r[i]   <= cacarb_pkg::RANGE_END_RST;
        addr_r[i]  <= cacarb_pkg::ADDR_NULL;
        rem_r[i]   <= cacarb_pkg::span(cacarb_pkg::RANGE_START_RST,
                                       cacarb_pkg::RANGE_END_RST);
      end
    end else begin
      sync_r  <= sync_nxt;
      name_r  <= name_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      addr_r  <= addr_nxt;
      rem_r   <= rem_nxt;
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r[0] <= 9'd256)
    else $error("front: address count above range size");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("front: item decoded into a full queue");
`endif

endmodule

/* sv/cacarb_fifo.sv */
// ----------------------------------------------------------------------------
// cacarb_fifo
// Short job queue between the arbitration and output sides.
// ----------------------------------------------------------------------------
module cacarb_fifo #(
  parameter int DEPTH = cacarb_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cacarb_pkg::job_t din,
  input  logic             pop,
  output cacarb_pkg::job_t dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cacarb_pkg::job_t     mem_r [DEPTH];
  logic [PW-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]        cnt_r,    cnt_nxt;

  assign empty = (cnt_r == CW'(0));
  assign full  = (cnt_r == CW'(DEPTH));
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo: occupancy above depth");
`endif

endmodule

/* sv/cacarb_back.sv */
// ----------------------------------------------------------------------------
// cacarb_back
// Expands queued jobs into claim beats through one output register.
// ----------------------------------------------------------------------------
module cacarb_back #(
  parameter int PORTS = cacarb_pkg::PORTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cacarb_pkg::job_t       head,
  input  logic                   head_valid,
  output logic                   pop,
  input  logic [PORTS-1:0][63:0] names,
  cacarb_out_if.source           out_bus
);

  logic        out_valid_r;
  logic        idx_r, idx_nxt;
  logic        load, two, is_last, p, np;
  logic [7:0]  addr;
  logic [63:0] name;

  logic        claim_port_r;
  logic [7:0]  claim_source_r;
  logic [63:0] claim_name_r;
  logic        cannot_claim_r;
  logic        filter_update_r;
  logic [7:0]  filter_address_r;
  logic        store_address_r;
  logic        last_r;

  assign two     = head.multi && (PORTS > 1);
  assign load    = head_valid && (!out_valid_r || out_bus.ready);
  assign is_last = !two || idx_r;
  assign pop     = load && is_last;
  assign p       = head.multi ? idx_r : head.port;
  assign np      = head.name0 ? 1'b0 : p;
  assign addr    = (head.multi && idx_r) ? head.addr_b : head.addr_a;
  assign idx_nxt = load ? !is_last : idx_r;

  always_comb begin
    name = names[0];
    for (int i = 0; i < PORTS; i++) begin
      if (i == int'(np)) begin
        name = names[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      claim_port_r     <= p;
      claim_source_r   <= addr;
      claim_name_r     <= name;
      cannot_claim_r   <= (addr == cacarb_pkg::ADDR_NULL);
      filter_update_r  <= head.filt;
      filter_address_r <= head.filt ? head.faddr : 8'd0;
      store_address_r  <= head.store && !p;
      last_r           <= is_last;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.claim_port     = claim_port_r;
  assign out_bus.claim_source   = claim_source_r;
  assign out_bus.claim_name     = claim_name_r;
  assign out_bus.cannot_claim   = cannot_claim_r;
  assign out_bus.filter_update  = filter_update_r;
  assign out_bus.filter_address = filter_address_r;
  assign out_bus.store_address  = store_address_r;
  assign out_bus.last           = last_r;

`ifndef SYNTH
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.ready && !out_bus.last
    |=> out_bus.valid && out_bus.last && out_bus.claim_port)
    else $error("back: sync pair not followed by port 1 final beat");

  a_step_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.filter_update &&
    (out_bus.filter_address != cacarb_pkg::ADDR_GLOBAL)
    |-> out_bus.claim_source == out_bus.filter_address)
    else $error("back: stepped claim source differs from filter address");
`endif

endmodule

/* sv/can_address_claim_arbiter.sv */
// ----------------------------------------------------------------------------
// can_address_claim_arbiter
// Address-claim arbiter for up to two CAN ports.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | beat contents
//  ---------+-----+--------------------+-------------------------------------
//  in_bus   | in  | valid/ready        | mode, port, address, their_name
//  out_bus  | out | valid/ready        | claim msg, filter update, store, last
//  cfg_*    | in  | cfg_we, no ready   | cfg_index, cfg_data (64 bits)
//
//  An event beat is taken whenever the job queue has room, one per cycle.
//  Arbitration and the address/count update finish in the accept cycle.
//  Output: one beat per cycle while out_bus.ready is high, single register;
//  sync claims/requests make two beats, other results one, no result none.
//  Output stalls back up through the 2-deep job queue to in_bus.ready.
//  Reset is synchronous (rst_n low); state is usable the next cycle.
//
// Front: config registers, per-port address and remaining-count state, NAME
// compare and address step. It queues a job holding the addresses after the
// update, so later events can change state before the beats go out.
// Back: walks a job into one or two beats, port 0 first in sync mode.
// ----------------------------------------------------------------------------
module can_address_claim_arbiter #(
  parameter int PORTS = cacarb_pkg::PORTS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  cacarb_in_if.sink                        in_bus,
  cacarb_out_if.source                     out_bus,
  input  logic                             cfg_we,
  input  logic [cacarb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                      cfg_data
);

  cacarb_pkg::job_t       job_in;
  cacarb_pkg::job_t       job_head;
  logic                   job_push;
  logic                   job_pop;
  logic                   q_empty;
  logic                   q_full;
  logic [PORTS-1:0][63:0] names;

  // arbitration side
  cacarb_front #(.PORTS(PORTS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (job_in),
    .push      (job_push),
    .full      (q_full),
    .names     (names)
  );

  // decouples event accept from output stalls
  cacarb_fifo #(.DEPTH(cacarb_pkg::QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .pop   (job_pop),
    .dout  (job_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // beats; NAMEs read live: user must write config only when idle (unchecked)
  cacarb_back #(.PORTS(PORTS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (job_head),
    .head_valid (!q_empty),
    .pop        (job_pop),
    .names      (names),
    .out_bus    (out_bus)
  );

endmodule

/* tb/sv/can_address_claim_arbiter_tb.sv */
// ----------------------------------------------------------------------------
// can_address_claim_arbiter_tb
// Self-checking bench for the two-port CAN address-claim arbiter: directed
// start/claim/request cases, range wrap and exhaustion, sync mode, output
// back-pressure, then randomized traffic over many register settings, each
// result beat scored against an in-bench predictor of the claim logic.
// ----------------------------------------------------------------------------
module can_address_claim_arbiter_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_EVENTS  = 210;
  localparam int RANDOM_PHASES = 9;

  // One expected result beat, laid out in port order of the result channel.
  typedef struct packed {
    logic        claim_port;
    logic [7:0]  claim_source;
    logic [63:0] claim_name;
    logic        cannot_claim;
    logic        filter_update;
    logic [7:0]  filter_address;
    logic        store_address;
    logic        last;
  } claim_beat_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [cacarb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [63:0] cfg_data;

  cacarb_in_if  in_bus ();
  cacarb_out_if out_bus ();

  can_address_claim_arbiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: register shadow plus per-port held address and the
  // count of addresses still left to try. Values match the block's reset.
  // --------------------------------------------------------------------------
  logic        sync_mode    = 1'b0;
  logic [63:0] own_name [2] = '{64'd0, 64'd0};
  logic [7:0]  rstart   [2] = '{cacarb_pkg::RANGE_START_RST, cacarb_pkg::RANGE_START_RST};
  logic [7:0]  rend     [2] = '{cacarb_pkg::RANGE_END_RST, cacarb_pkg::RANGE_END_RST};
  logic [7:0]  held     [2] = '{cacarb_pkg::ADDR_NULL, cacarb_pkg::ADDR_NULL};
  logic [8:0]  remaining[2] = '{9'd120, 9'd120};

  claim_beat_t pending_claims[$];

  int failures     = 0;
  int cycle_count  = 0;
  int hold_off_len = 0;  // one-shot request for a long receiver stall
  bit sender_idling = 1'b1;
  bit sink_idling   = 1'b1;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Queue one expected beat; source and NAME are taken after the update.
  function automatic void push_claim(input logic p, input logic filt,
                                     input logic [7:0] faddr, input logic store,
                                     input logic fin);
    claim_beat_t b;
    b.claim_port     = p;
    b.claim_source   = held[p];
    b.claim_name     = own_name[sync_mode ? 1'b0 : p];
    b.cannot_claim   = (held[p] == cacarb_pkg::ADDR_NULL);
    b.filter_update  = filt;
    b.filter_address = filt ? faddr : 8'd0;
    b.store_address  = store;
    b.last           = fin;
    pending_claims.push_back(b);
  endfunction

  // Advance the predictor by one accepted event and queue its results.
  function automatic void predict_claims(input cacarb_pkg::mode_t m, input logic p,
                                         input logic [7:0] a, input logic [63:0] theirs);
    logic       c;
    logic       filt;
    logic       store;
    logic [7:0] na;
    logic [7:0] faddr;
    filt  = 1'b0;
    store = 1'b0;
    faddr = 8'd0;
    if (m == cacarb_pkg::MODE_UNUSED) return;
    if (m == cacarb_pkg::MODE_START) begin
      // start claim loads the port only, even in sync mode; global reads as null
      held[p] = (a == cacarb_pkg::ADDR_GLOBAL) ? cacarb_pkg::ADDR_NULL : a;
      push_claim(p, 1'b0, 8'd0, 1'b0, 1'b1);
      return;
    end
    c = sync_mode ? 1'b0 : p;  // port 0 arbitrates for all in sync mode
    if (m == cacarb_pkg::MODE_CLAIM) begin
      if (a == cacarb_pkg::ADDR_NULL || a != held[c]) return;
      // equal or higher own NAME loses
      if (own_name[c] >= theirs) begin
        if (own_name[c][63] && remaining[c] != 9'd0) begin
          remaining[c] = remaining[c] - 9'd1;
          na = held[c] + 8'd1;
          if (na > rend[c] || na < rstart[c]) na = rstart[c];
          faddr = na;
          store = (c == 1'b0);
        end else begin
          na    = cacarb_pkg::ADDR_NULL;
          faddr = cacarb_pkg::ADDR_GLOBAL;
        end
        filt = 1'b1;
        if (sync_mode) begin
          held[0] = na;
          held[1] = na;
        end else begin
          held[c] = na;
        end
      end
    end
    if (sync_mode) begin
      push_claim(1'b0, filt, faddr, store, 1'b0);
      push_claim(1'b1, filt, faddr, 1'b0, 1'b1);
    end else begin
      push_claim(c, filt, faddr, store, 1'b1);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one event beat; valid stays high on return so a following beat
  // can go out back to back. Callers that pause lower it first.
  task automatic send_event(input cacarb_pkg::mode_t m, input logic p, input logic [7:0] a,
                            input logic [63:0] nm);
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.mode       <= m;
    in_bus.port       <= p;
    in_bus.address    <= a;
    in_bus.their_name <= nm;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    predict_claims(m, p, a, nm);
  endtask

  // Stop offering and wait for every expected beat, plus a few cycles for
  // events that make no beats.
  task automatic quiesce();
    in_bus.valid <= 1'b0;
    while (pending_claims.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all seven registers, one per cycle. Called only when idle.
  task automatic apply_config(input logic sm, input logic [63:0] n0, input logic [63:0] n1,
                              input logic [7:0] s0, input logic [7:0] e0,
                              input logic [7:0] s1, input logic [7:0] e1);
    cacarb_pkg::cfg_idx_t idx [7];
    logic [63:0]          vals[7];
    idx  = '{cacarb_pkg::CFG_SYNC, cacarb_pkg::CFG_NAME0, cacarb_pkg::CFG_NAME1,
             cacarb_pkg::CFG_START0, cacarb_pkg::CFG_END0, cacarb_pkg::CFG_START1,
             cacarb_pkg::CFG_END1};
    vals = '{{63'd0, sm}, n0, n1, {56'd0, s0}, {56'd0, e0}, {56'd0, s1}, {56'd0, e1}};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    sync_mode = sm;
    own_name  = '{n0, n1};
    rstart    = '{s0, s1};
    rend      = '{e0, e1};
    // any range write reloads the count; an inverted range leaves none
    for (int q = 0; q < 2; q++) begin
      remaining[q] = (rend[q] < rstart[q]) ? 9'd0
                   : {1'b0, rend[q]} - {1'b0, rstart[q]} + 9'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Out of reset both ports hold null; global preferred address reads as null.
  task automatic test_start_claims();
    send_event(cacarb_pkg::MODE_REQUEST, 1'b0, 8'd0, 64'd0);
    send_event(cacarb_pkg::MODE_REQUEST, 1'b1, 8'd255, '1);
    send_event(cacarb_pkg::MODE_START, 1'b0, cacarb_pkg::ADDR_GLOBAL, 64'd0);
    send_event(cacarb_pkg::MODE_START, 1'b1, 8'd0, '1);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd253, 64'd0);
    quiesce();
  endtask

  // Win, loss with step, ignored sources, non-configurable loser, unused mode.
  task automatic test_arbitration();
    logic [63:0] n0;
    logic [63:0] n1;
    n0 = 64'h8000_0000_0000_0100;
    n1 = 64'h0000_0000_0000_0055;
    apply_config(1'b0, n0, n1, cacarb_pkg::RANGE_START_RST, cacarb_pkg::RANGE_END_RST,
                 cacarb_pkg::RANGE_START_RST, cacarb_pkg::RANGE_END_RST);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd128, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd128, '1);      // their NAME higher: we win
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd128, n0);      // equal NAME: we lose, step
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, cacarb_pkg::ADDR_NULL, 64'd0); // null: ignored
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd77, 64'd0);    // other address: ignored
    send_event(cacarb_pkg::MODE_START, 1'b1, 8'd200, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b1, 8'd200, 64'd0);   // not self-config: to null
    send_event(cacarb_pkg::MODE_UNUSED, 1'b0, 8'd129, 64'd0);
    quiesce();
  endtask

  // Step wrap past the range end and from below the start, count exhaustion,
  // and an inverted range that leaves no addresses at all.
  task automatic test_range_wrap();
    logic [63:0] n0;
    logic [63:0] n1;
    n0 = 64'h8000_0000_0000_0001;
    n1 = 64'h8000_0000_0000_0002;
    apply_config(1'b0, n0, n1, 8'd250, 8'd253, 8'd9, 8'd3);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd253, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd253, 64'd0);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd3, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd3, 64'd0);
    send_event(cacarb_pkg::MODE_START, 1'b1, 8'd5, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b1, 8'd5, 64'd0);
    quiesce();
    apply_config(1'b0, n0, n1, 8'd10, 8'd10, 8'd9, 8'd3);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd10, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd10, 64'd0);    // last address used up
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd10, 64'd0);    // none left: null
    quiesce();
  endtask

  // Port 0 speaks for both ports; two beats per claim or request, store on port 0 only.
  task automatic test_sync_mode();
    logic [63:0] n0;
    n0 = 64'h8000_0000_00AB_CDEF;
    apply_config(1'b1, n0, 64'h0123_4567_89AB_CDEF, cacarb_pkg::RANGE_START_RST,
                 cacarb_pkg::RANGE_END_RST, cacarb_pkg::RANGE_START_RST,
                 cacarb_pkg::RANGE_END_RST);
    send_event(cacarb_pkg::MODE_START, 1'b1, 8'd40, 64'd0);
    send_event(cacarb_pkg::MODE_START, 1'b0, 8'd130, 64'd0);
    send_event(cacarb_pkg::MODE_REQUEST, 1'b1, 8'd0, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b1, 8'd130, 64'd0);
    send_event(cacarb_pkg::MODE_CLAIM, 1'b0, 8'd131, '1);
    quiesce();
  endtask

  // Receiver stalls for a long stretch while events keep coming, so the job
  // queue fills and the input side has to back off.
  task automatic test_backpressure();
    sender_idling = 1'b0;
    hold_off_len  = 200;
    for (int i = 0; i < 12; i++) begin
      send_event(cacarb_pkg::MODE_REQUEST, 1'(i), 8'(i), 64'd0);
    end
    quiesce();
    sender_idling = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------

  // Pick a register setting; early phases pin the extremes.
  task automatic random_config(input int phase);
    logic [7:0]  s[2];
    logic [7:0]  e[2];
    logic [63:0] n[2];
    logic        sm;
    sm = 1'($urandom_range(0, 1));
    for (int q = 0; q < 2; q++) begin
      case ($urandom_range(0, 4))
        0: begin
          s[q] = 8'd0;
          e[q] = 8'd253;
        end
        1: begin
          s[q] = 8'($urandom_range(0, 253));
          e[q] = s[q];
        end
        2: begin
          s[q] = 8'($urandom_range(0, 248));
          e[q] = s[q] + 8'($urandom_range(0, 5));
        end
        3: begin
          e[q] = 8'($urandom_range(0, 252));
          s[q] = 8'($urandom_range(e[q] + 1, 253));
        end
        default: begin
          s[q] = 8'($urandom_range(0, 253));
          e[q] = 8'($urandom_range(0, 253));
        end
      endcase
      n[q] = {$urandom, $urandom};
      if ($urandom_range(0, 3) != 0) n[q][63] = 1'b1;
    end
    if (phase == 0) begin
      sm = 1'b0;
      n  = '{64'd0, 64'd0};
      s  = '{8'd0, 8'd0};
      e  = '{8'd253, 8'd253};
    end else if (phase == 1) begin
      // all-ones NAME never wins; small ranges run out quickly
      sm = 1'b1;
      n  = '{'1, '1};
      s  = '{8'd253, 8'd0};
      e  = '{8'd253, 8'd0};
    end
    apply_config(sm, n[0], n[1], s[0], e[0], s[1], e[1]);
  endtask

  // Mostly claims aimed at the arbitrating port's own address with NAMEs
  // near our own, so arbitration, stepping and exhaustion keep happening.
  task automatic send_random_event();
    int                pick;
    cacarb_pkg::mode_t m;
    logic              p;
    logic              c;
    logic [7:0]        a;
    logic [63:0]       nm;
    logic [63:0]       own;
    pick = $urandom_range(0, 99);
    p    = 1'($urandom_range(0, 1));
    c    = sync_mode ? 1'b0 : p;
    a    = 8'($urandom_range(0, 255));
    nm   = {$urandom, $urandom};
    own  = own_name[c];
    if (pick < 15) begin
      m = cacarb_pkg::MODE_START;
      if (pick >= 4) a = 8'($urandom_range(rstart[p], rend[p]));
    end else if (pick < 70) begin
      m = cacarb_pkg::MODE_CLAIM;
      a = held[c];
      case ($urandom_range(0, 5))
        0: nm = own;
        1: nm = own + 64'd1;
        2: nm = own - 64'd1;
        3: nm = 64'd0;
        4: nm = '1;
        default: ;
      endcase
    end else if (pick < 82) begin
      m = cacarb_pkg::MODE_REQUEST;
    end else if (pick < 95) begin
      m = cacarb_pkg::MODE_CLAIM;
    end else begin
      m = cacarb_pkg::MODE_UNUSED;
    end
    send_event(m, p, a, nm);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiesce();
      random_config(phase);
      if (phase == RANDOM_PHASES - 1) begin
        // closing stretch runs at full rate on both sides
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
      end else begin
        sender_idling = (phase % 3 != 2);
        sink_idling   = (phase % 4 != 3);
      end
      for (int i = 0; i < PHASE_EVENTS; i++) begin
        send_random_event();
      end
    end
    quiesce();
  endtask

  // --------------------------------------------------------------------------
  // Result side: score each accepted beat, then pick next cycle's ready.
  // Values are read right after the edge, i.e. as they were at the edge.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    claim_beat_t got;
    claim_beat_t want;
    int          stall;
    stall         = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        got = {out_bus.claim_port, out_bus.claim_source, out_bus.claim_name,
               out_bus.cannot_claim, out_bus.filter_update, out_bus.filter_address,
               out_bus.store_address, out_bus.last};
        if (pending_claims.size() == 0) begin
          $error("result beat with no expected claim: source %0d port %0d",
                 got.claim_source, got.claim_port);
          failures++;
        end else begin
          want = pending_claims.pop_front();
          if (got.claim_port !== want.claim_port) begin
            $error("claim_port: expected %0d, got %0d", want.claim_port, got.claim_port);
            failures++;
          end
          if (got.claim_source !== want.claim_source) begin
            $error("claim_source: expected %0d, got %0d",
                   want.claim_source, got.claim_source);
            failures++;
          end
          if (got.claim_name !== want.claim_name) begin
            $error("claim_name: expected %h, got %h", want.claim_name, got.claim_name);
            failures++;
          end
          if (got.cannot_claim !== want.cannot_claim) begin
            $error("cannot_claim: expected %0d, got %0d",
                   want.cannot_claim, got.cannot_claim);
            failures++;
          end
          if (got.filter_update !== want.filter_update) begin
            $error("filter_update: expected %0d, got %0d",
                   want.filter_update, got.filter_update);
            failures++;
          end
          if (got.filter_address !== want.filter_address) begin
            $error("filter_address: expected %0d, got %0d",
                   want.filter_address, got.filter_address);
            failures++;
          end
          if (got.store_address !== want.store_address) begin
            $error("store_address: expected %0d, got %0d",
                   want.store_address, got.store_address);
            failures++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            failures++;
          end
        end
      end
      // long hold-off takes priority over random bursts
      if (hold_off_len > 0) begin
        stall        = hold_off_len;
        hold_off_len = 0;
      end else if (stall == 0 && sink_idling && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 8);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = cacarb_pkg::CFG_SYNC;
    cfg_data          = 64'd0;
    in_bus.valid      = 1'b0;
    in_bus.mode       = cacarb_pkg::MODE_START;
    in_bus.port       = 1'b0;
    in_bus.address    = 8'd0;
    in_bus.their_name = 64'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_start_claims();
    test_arbitration();
    test_range_wrap();
    test_sync_mode();
    test_backpressure();
    test_random_traffic();

    // quiesce has drained every beat; allow a little extra for stragglers
    repeat (10) @(posedge clk);
    if (pending_claims.size() != 0) begin
      $error("%0d expected claim beats never arrived", pending_claims.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
